@@ rtl/core/tmtw_pkg.sv @@
// Shared types, constants and helpers for the text-mode terminal writer.
// Depends on nothing; the top, sequencer, cursor and testbench import it.
`timescale 1ns / 1ps

package tmtw_pkg;

	localparam int COLUMNS      = 80;
	localparam int ROWS         = 25;
	localparam int TAB_WIDTH    = 8;
	localparam int CELL_COUNT   = ROWS * COLUMNS;
	localparam int SCROLL_CELLS = (ROWS - 1) * COLUMNS;
	localparam int TAB_STOPS    = COLUMNS / TAB_WIDTH + 1;

	localparam int COL_W  = $clog2(COLUMNS);
	localparam int ROW_W  = $clog2(ROWS);
	localparam int NCOL_W = $clog2(COLUMNS + TAB_WIDTH + 1);
	localparam int NROW_W = $clog2(ROWS + 1);
	localparam int ADDR_W = 11;
	localparam int WORD_W = 16;
	localparam int CHAR_W = 8;

	localparam logic [1:0] OP_PUT   = 2'd0;
	localparam logic [1:0] OP_CLEAR = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	localparam logic [CHAR_W-1:0] CHAR_BS       = 8'h08;
	localparam logic [CHAR_W-1:0] CHAR_TAB      = 8'h09;
	localparam logic [CHAR_W-1:0] CHAR_LF       = 8'h0A;
	localparam logic [CHAR_W-1:0] CHAR_CR       = 8'h0D;
	localparam logic [CHAR_W-1:0] CHAR_PRINT_LO = 8'h20;
	localparam logic [CHAR_W-1:0] CHAR_PRINT_HI = 8'h7F;

	localparam logic [WORD_W-1:0] BLANK_RESET = 16'h0F20;

	typedef struct packed {
		logic [1:0]        operation;
		logic [WORD_W-1:0] char_word;
		logic [ADDR_W-1:0] cell_address;
	} req_t;

	typedef struct packed {
		logic [ADDR_W-1:0] cursor_location;
		logic [CHAR_W-1:0] echoed_char;
		logic [WORD_W-1:0] cell_data;
	} rsp_t;

	typedef struct packed {
		logic              put;
		logic              home;
		logic [CHAR_W-1:0] code;
	} cur_cmd_t;

	typedef struct packed {
		logic [ADDR_W-1:0] loc;
		logic              printable;
		logic              scroll;
	} cur_stat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PUT,
		ST_READ,
		ST_SCROLL,
		ST_FILL,
		ST_FINISH
	} state_t;

	// Smallest multiple of TAB_WIDTH strictly above the given column.
	function automatic logic [NCOL_W-1:0] tab_stop(input logic [COL_W-1:0] col);
		logic [NCOL_W-1:0] stop;
		stop = '0;
		for (int k = TAB_STOPS; k >= 1; k--) begin
			if (NCOL_W'(k * TAB_WIDTH) > NCOL_W'(col)) begin
				stop = NCOL_W'(k * TAB_WIDTH);
			end
		end
		return stop;
	endfunction

endpackage

@@ rtl/core/text_mode_terminal_writer_unit.sv @@
// Text-mode terminal writer: 80x25 cell store with a cursor.
// Channels: req (valid/ready) carries one transaction of operation, char_word
// and cell_address; rsp (valid/ready) returns cursor_location, echoed_char and
// cell_data, one result per transaction.
// cfg_we/cfg_wdata write blank_cell, the word used for clear and scroll fill.
// One transaction is worked on at a time. From acceptance to the result:
//   read and any put that does not scroll: the read or put step, then the result;
//   unused operation code: straight to the result;
//   put that scrolls: the put, the copy one row up, the bottom-row fill;
//   clear: a fill of the whole screen.
// Scroll and clear sweep the single-write-port cell RAM one cell per cycle,
// stepped by the sequencer's address counter.
// Reset homes the cursor and sets blank_cell to 0x0F20; the cell store is
// undefined until the first clear.
// A result waits in an output register while rsp_ready is low; the next
// transaction is still accepted, and its result waits until that one is taken.
`timescale 1ns / 1ps

module text_mode_terminal_writer_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  tmtw_pkg::req_t              req,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output tmtw_pkg::rsp_t              rsp,
	input  logic                        cfg_we,
	input  logic [tmtw_pkg::WORD_W-1:0] cfg_wdata
);
	import tmtw_pkg::*;

	logic [WORD_W-1:0] blank_cell_q;
	cur_cmd_t          cur_cmd;
	cur_stat_t         cur_stat;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [WORD_W-1:0] ram_wdata;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_raddr;
	logic [WORD_W-1:0] ram_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blank_cell_q <= BLANK_RESET;
		end else if (cfg_we) begin
			blank_cell_q <= cfg_wdata;
		end
	end

	tmtw_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp),
		.blank_cell (blank_cell_q),
		.cur_cmd    (cur_cmd),
		.cur_stat   (cur_stat),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata),
		.ram_re     (ram_re),
		.ram_raddr  (ram_raddr),
		.ram_rdata  (ram_rdata)
	);

	tmtw_cursor u_cursor (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cur_cmd),
		.stat   (cur_stat)
	);

	tmtw_ram #(
		.WIDTH (WORD_W),
		.DEPTH (CELL_COUNT)
	) u_cells (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Only one transaction is in work at a time.
	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("transaction accepted while another is in work");

	// The cursor never leaves the screen.
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.cursor_location < ADDR_W'(CELL_COUNT))
		else $error("cursor location off screen");

	// A result never carries both a put echo and read data.
	a_echo_or_data: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.echoed_char == '0 || rsp.cell_data == '0))
		else $error("result carries both an echo and cell data");

	// The store is never written while the block waits for a transaction.
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		req_ready |-> !ram_we)
		else $error("cell store written while idle");

endmodule

@@ rtl/core/tmtw_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module tmtw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		// The read data holds while no read is issued.
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/core/tmtw_cursor.sv @@
// Cursor registers and put-code decoding: movement, wrap and scroll detection.
// Depends on tmtw_pkg.
`timescale 1ns / 1ps

module tmtw_cursor (
	input  logic                clk,
	input  logic                arst_n,
	input  tmtw_pkg::cur_cmd_t  cmd,
	output tmtw_pkg::cur_stat_t stat
);
	import tmtw_pkg::*;

	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [NCOL_W-1:0] ncol;
	logic [NROW_W-1:0] nrow;
	logic              printable;
	logic              scroll;

	always_comb begin
		printable = cmd.code inside {[CHAR_PRINT_LO:CHAR_PRINT_HI]};
		ncol      = NCOL_W'(col_q);
		nrow      = NROW_W'(row_q);
		case (cmd.code)
			CHAR_BS: begin
				if (col_q != '0) begin
					ncol = NCOL_W'(col_q) - NCOL_W'(1);
				end
			end
			CHAR_TAB: begin
				ncol = tab_stop(col_q);
			end
			CHAR_CR: begin
				ncol = '0;
			end
			CHAR_LF: begin
				ncol = '0;
				nrow = NROW_W'(row_q) + NROW_W'(1);
			end
			default: begin
				if (printable) begin
					ncol = NCOL_W'(col_q) + NCOL_W'(1);
				end
			end
		endcase
		if (ncol >= NCOL_W'(COLUMNS)) begin
			ncol = '0;
			nrow = nrow + NROW_W'(1);
		end
		scroll = nrow >= NROW_W'(ROWS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cmd.home) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cmd.put) begin
			col_q <= COL_W'(ncol);
			row_q <= scroll ? ROW_W'(ROWS - 1) : ROW_W'(nrow);
		end
	end

	assign stat.loc       = ADDR_W'(row_q) * ADDR_W'(COLUMNS) + ADDR_W'(col_q);
	assign stat.printable = printable;
	assign stat.scroll    = scroll;

endmodule

@@ rtl/core/tmtw_seq.sv @@
// Sequencer: accepts a transaction, drives the cell store through one shared
// address counter for scroll and fill sweeps, and holds the result register.
// Depends on tmtw_pkg.
`timescale 1ns / 1ps

module tmtw_seq (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_ready,
	input  tmtw_pkg::req_t                      req,
	output logic                                rsp_valid,
	input  logic                                rsp_ready,
	output tmtw_pkg::rsp_t                      rsp,
	input  logic [tmtw_pkg::WORD_W-1:0]         blank_cell,
	output tmtw_pkg::cur_cmd_t                  cur_cmd,
	input  tmtw_pkg::cur_stat_t                 cur_stat,
	output logic                                ram_we,
	output logic [tmtw_pkg::ADDR_W-1:0]         ram_waddr,
	output logic [tmtw_pkg::WORD_W-1:0]         ram_wdata,
	output logic                                ram_re,
	output logic [tmtw_pkg::ADDR_W-1:0]         ram_raddr,
	input  logic [tmtw_pkg::WORD_W-1:0]         ram_rdata
);
	import tmtw_pkg::*;

	state_t            state_q, state_d;
	logic [1:0]        op_q;
	logic [WORD_W-1:0] word_q;
	logic [ADDR_W-1:0] addr_q;
	logic [ADDR_W-1:0] cnt_q;
	logic              rsp_valid_q;
	rsp_t              rsp_q;
	logic              addr_ok;
	logic              rsp_load;
	logic              accept;
	logic              sweep_start;
	logic [ADDR_W-1:0] sweep_base;

	assign addr_ok = addr_q < ADDR_W'(CELL_COUNT);
	assign accept  = req_valid && req_ready;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					case (req.operation)
						OP_PUT:   state_d = ST_PUT;
						OP_CLEAR: state_d = ST_FILL;
						OP_READ:  state_d = ST_READ;
						default:  state_d = ST_FINISH;
					endcase
				end
			end
			ST_PUT: begin
				state_d = cur_stat.scroll ? ST_SCROLL : ST_FINISH;
			end
			ST_READ: begin
				state_d = ST_FINISH;
			end
			ST_SCROLL: begin
				if (cnt_q == ADDR_W'(SCROLL_CELLS)) begin
					state_d = ST_FILL;
				end
			end
			ST_FILL: begin
				if (cnt_q == ADDR_W'(CELL_COUNT - 1)) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!rsp_valid_q || rsp_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		req_ready    = 1'b0;
		ram_we       = 1'b0;
		ram_waddr    = cnt_q;
		ram_wdata    = blank_cell;
		ram_re       = 1'b0;
		ram_raddr    = cnt_q + ADDR_W'(COLUMNS);
		cur_cmd.put  = 1'b0;
		cur_cmd.home = 1'b0;
		cur_cmd.code = word_q[CHAR_W-1:0];
		rsp_load     = 1'b0;
		sweep_start  = 1'b0;
		sweep_base   = '0;
		case (state_q)
			ST_IDLE: begin
				req_ready   = 1'b1;
				sweep_start = 1'b1;
			end
			ST_PUT: begin
				ram_we      = cur_stat.printable;
				ram_waddr   = cur_stat.loc;
				ram_wdata   = word_q;
				cur_cmd.put = 1'b1;
				sweep_start = 1'b1;
			end
			ST_READ: begin
				ram_re    = addr_ok;
				ram_raddr = addr_q;
			end
			ST_SCROLL: begin
				// Read one row ahead; write the word read last cycle one cell back.
				ram_re    = cnt_q < ADDR_W'(SCROLL_CELLS);
				ram_we    = cnt_q != '0;
				ram_waddr = cnt_q - ADDR_W'(1);
				ram_wdata = ram_rdata;
			end
			ST_FILL: begin
				ram_we       = 1'b1;
				cur_cmd.home = op_q == OP_CLEAR;
			end
			ST_FINISH: begin
				rsp_load = !rsp_valid_q || rsp_ready;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			state_q <= state_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (sweep_start) begin
				cnt_q <= sweep_base;
			end else if (state_q == ST_SCROLL && cnt_q == ADDR_W'(SCROLL_CELLS)) begin
				// The fill of the bottom row starts where the copy ended.
				cnt_q <= cnt_q;
			end else if (state_q == ST_SCROLL || state_q == ST_FILL) begin
				cnt_q <= cnt_q + ADDR_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= req.operation;
			word_q <= req.char_word;
			addr_q <= req.cell_address;
		end
		if (rsp_load) begin
			rsp_q.cursor_location <= cur_stat.loc;
			rsp_q.echoed_char     <= (op_q == OP_PUT) ? word_q[CHAR_W-1:0] : '0;
			rsp_q.cell_data       <= (op_q == OP_READ && addr_ok) ? ram_rdata : '0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for the text-mode terminal writer (text_mode_terminal_writer_unit).
// Depends on tmtw_pkg for the request and result structs, the operation codes and the sizes.
`timescale 1ns / 1ps

module testbench;
	import tmtw_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam int WATCHDOG_LIMIT  = 20000;
	localparam int DRAIN_CYCLES    = 2100;
	localparam int SETTLE_CYCLES   = 4;
	localparam int PHASES          = 6;
	localparam int PHASE_ITEMS     = 50;
	localparam int HOLD_OFF_CYCLES = 80;
	localparam int MAX_REPORTS     = 40;
	localparam int DIRECTED_COUNT  = 21;

	typedef struct packed {
		logic [1:0]        op;
		logic [WORD_W-1:0] word;
		logic [ADDR_W-1:0] addr;
		logic              fixed;
		rsp_t              want;
	} step_t;

	// Rows marked fixed carry the result typed in; the rest rely on the terminal model.
	step_t directed_steps [DIRECTED_COUNT] = '{
		'{OP_UNUSED, 16'hFFFF, 11'h7FF, 1'b1, {11'd0, 8'h00, 16'h0000}},
		'{OP_READ,   16'h0000, 11'h7FF, 1'b1, {11'd0, 8'h00, 16'h0000}},
		'{OP_READ,   16'hFFFF, 11'd2000, 1'b1, {11'd0, 8'h00, 16'h0000}},
		'{OP_PUT,    16'h0008, 11'd0,   1'b1, {11'd0, 8'h08, 16'h0000}},
		'{OP_PUT,    16'hFFFF, 11'h7FF, 1'b1, {11'd0, 8'hFF, 16'h0000}},
		'{OP_PUT,    16'h0041, 11'd0,   1'b1, {11'd1, 8'h41, 16'h0000}},
		'{OP_READ,   16'h0000, 11'd0,   1'b1, {11'd1, 8'h00, 16'h0041}},
		'{OP_CLEAR,  16'hFFFF, 11'h7FF, 1'b1, {11'd0, 8'h00, 16'h0000}},
		'{OP_READ,   16'h0000, 11'd1999, 1'b1, {11'd0, 8'h00, 16'h0F20}},
		'{OP_PUT,    16'h7F7F, 11'd0,   1'b1, {11'd1, 8'h7F, 16'h0000}},
		'{OP_PUT,    16'hFF20, 11'd0,   1'b1, {11'd2, 8'h20, 16'h0000}},
		'{OP_PUT,    16'h0009, 11'd0,   1'b1, {11'd8, 8'h09, 16'h0000}},
		'{OP_PUT,    16'h0008, 11'd0,   1'b1, {11'd7, 8'h08, 16'h0000}},
		'{OP_PUT,    16'h000D, 11'd0,   1'b1, {11'd0, 8'h0D, 16'h0000}},
		'{OP_PUT,    16'h000A, 11'd0,   1'b1, {11'd80, 8'h0A, 16'h0000}},
		'{OP_PUT,    16'h001F, 11'd0,   1'b1, {11'd80, 8'h1F, 16'h0000}},
		'{OP_PUT,    16'h0080, 11'd0,   1'b1, {11'd80, 8'h80, 16'h0000}},
		'{OP_READ,   16'h0000, 11'd1,   1'b1, {11'd80, 8'h00, 16'hFF20}},
		'{OP_READ,   16'h0000, 11'd0,   1'b1, {11'd80, 8'h00, 16'h7F7F}},
		'{OP_PUT,    16'h8E3C, 11'h555, 1'b0, {11'd0, 8'h00, 16'h0000}},
		'{OP_READ,   16'h1234, 11'd80,  1'b0, {11'd0, 8'h00, 16'h0000}}
	};

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t term_request;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t term_result;
	logic cfg_we;
	logic [WORD_W-1:0] cfg_wdata;

	// Terminal model state.
	logic [WORD_W-1:0] screen [CELL_COUNT];
	bit                cell_known [CELL_COUNT];
	int unsigned       cur_col;
	int unsigned       cur_row;
	logic [WORD_W-1:0] blank_word;

	rsp_t terminal_results_due [$];
	rsp_t oldest_due;
	int   mismatch_count;
	int   results_seen;
	int   idle_cycles;
	int   burst_left;
	int   text_left;
	bit   hold_off_pending;

	text_mode_terminal_writer_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (term_request),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (term_result),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic rsp_t advance_terminal(input req_t r);
		rsp_t              res;
		logic [CHAR_W-1:0] code;
		res  = '0;
		code = r.char_word[CHAR_W-1:0];
		case (r.operation)
			OP_PUT: begin
				if (code == CHAR_BS) begin
					if (cur_col > 0) begin
						cur_col--;
					end
				end else if (code == CHAR_TAB) begin
					cur_col = cur_col + TAB_WIDTH - cur_col % TAB_WIDTH;
				end else if (code == CHAR_CR) begin
					cur_col = 0;
				end else if (code == CHAR_LF) begin
					cur_col = 0;
					cur_row++;
				end else if (code >= CHAR_PRINT_LO && code <= CHAR_PRINT_HI) begin
					screen[cur_row * COLUMNS + cur_col]     = r.char_word;
					cell_known[cur_row * COLUMNS + cur_col] = 1'b1;
					cur_col++;
				end
				if (cur_col >= COLUMNS) begin
					cur_col = 0;
					cur_row++;
				end
				if (cur_row >= ROWS) begin
					for (int i = 0; i < SCROLL_CELLS; i++) begin
						screen[i]     = screen[i + COLUMNS];
						cell_known[i] = cell_known[i + COLUMNS];
					end
					for (int i = SCROLL_CELLS; i < CELL_COUNT; i++) begin
						screen[i]     = blank_word;
						cell_known[i] = 1'b1;
					end
					cur_row = ROWS - 1;
				end
				res.echoed_char = code;
			end
			OP_CLEAR: begin
				for (int i = 0; i < CELL_COUNT; i++) begin
					screen[i]     = blank_word;
					cell_known[i] = 1'b1;
				end
				cur_col = 0;
				cur_row = 0;
			end
			OP_READ: begin
				if (r.cell_address < CELL_COUNT) begin
					res.cell_data = screen[r.cell_address];
				end
			end
			default: begin
			end
		endcase
		res.cursor_location = ADDR_W'(cur_row * COLUMNS + cur_col);
		return res;
	endfunction

	// A read never targets a cell that holds nothing defined yet; such picks go out of range.
	function automatic logic [ADDR_W-1:0] pick_read_address();
		int a;
		if ($urandom_range(0, 4) == 0) begin
			a = $urandom_range(CELL_COUNT, 2**ADDR_W - 1);
		end else begin
			a = $urandom_range(0, CELL_COUNT - 1);
		end
		if (a < CELL_COUNT && !cell_known[a]) begin
			a = CELL_COUNT + a % (2**ADDR_W - CELL_COUNT);
		end
		return ADDR_W'(a);
	endfunction

	// Text comes in runs of mostly printable characters, broken up by line controls and other operations.
	function automatic req_t next_random_item();
		req_t r;
		int   pick;
		r.operation    = OP_PUT;
		r.char_word    = WORD_W'($urandom);
		r.cell_address = ADDR_W'($urandom);
		pick           = $urandom_range(0, 99);
		if (text_left > 0) begin
			text_left--;
			if (pick < 75) begin
				r.char_word[CHAR_W-1:0] = CHAR_W'($urandom_range(CHAR_PRINT_LO, CHAR_PRINT_HI));
			end else if (pick < 82) begin
				r.char_word[CHAR_W-1:0] = CHAR_TAB;
			end else if (pick < 86) begin
				r.char_word[CHAR_W-1:0] = CHAR_BS;
			end else begin
				r.operation    = OP_READ;
				r.cell_address = pick_read_address();
			end
		end else begin
			text_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 100) : $urandom_range(0, 8);
			if (pick < 35) begin
				r.char_word[CHAR_W-1:0] = CHAR_LF;
			end else if (pick < 50) begin
				r.char_word[CHAR_W-1:0] = CHAR_CR;
			end else if (pick < 65) begin
				if ($urandom_range(0, 1) == 1) begin
					r.char_word[CHAR_W-1:0] = CHAR_W'($urandom_range(8'h80, 8'hFF));
				end else begin
					r.char_word[CHAR_W-1:0] = CHAR_W'($urandom_range(8'h00, 8'h1F));
				end
			end else if (pick < 80) begin
				r.operation    = OP_READ;
				r.cell_address = pick_read_address();
			end else if (pick < 90) begin
				r.operation = OP_UNUSED;
			end else begin
				r.operation = OP_CLEAR;
			end
		end
		return r;
	endfunction

	task automatic note_mismatch(input string msg);
		if (mismatch_count < MAX_REPORTS) begin
			$display("MISMATCH: %s", msg);
		end
		mismatch_count++;
	endtask

	// Called at a falling edge; returns at the falling edge after the transaction is accepted.
	task automatic offer_item(input req_t r, input logic fixed, input rsp_t fixed_want);
		rsp_t predicted;
		if (burst_left == 0) begin
			req_valid <= 1'b0;
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(20, 40)) @(negedge clk);
			end else begin
				repeat ($urandom_range(1, 6)) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
		end
		term_request <= r;
		req_valid    <= 1'b1;
		do @(posedge clk); while (!req_ready);
		predicted = advance_terminal(r);
		terminal_results_due.push_back(fixed ? fixed_want : predicted);
		burst_left--;
		@(negedge clk);
	endtask

	// Receiver: switches between always ready, random stalls and a sparse pattern, and holds off once.
	initial begin
		int style;
		int style_left;
		style      = 0;
		style_left = 0;
		rsp_ready  = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_pending) begin
				hold_off_pending = 1'b0;
				rsp_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
			end else begin
				if (style_left == 0) begin
					style      = $urandom_range(0, 2);
					style_left = $urandom_range(20, 150);
				end
				style_left--;
				case (style)
					0: rsp_ready <= 1'b1;
					1: rsp_ready <= ($urandom_range(0, 99) < 60);
					default: rsp_ready <= (style_left % 4 == 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("text_mode_terminal_writer_unit test failed");
			$finish;
		end else if (arst_n && rsp_valid && rsp_ready) begin
			if (terminal_results_due.size() == 0) begin
				note_mismatch($sformatf("unexpected result, cursor_location %0d",
					term_result.cursor_location));
			end else begin
				oldest_due = terminal_results_due.pop_front();
				if (term_result.cursor_location !== oldest_due.cursor_location) begin
					note_mismatch($sformatf("result %0d cursor_location got %0d want %0d",
						results_seen, term_result.cursor_location, oldest_due.cursor_location));
				end
				if (term_result.echoed_char !== oldest_due.echoed_char) begin
					note_mismatch($sformatf("result %0d echoed_char got %h want %h",
						results_seen, term_result.echoed_char, oldest_due.echoed_char));
				end
				if (term_result.cell_data !== oldest_due.cell_data) begin
					note_mismatch($sformatf("result %0d cell_data got %h want %h",
						results_seen, term_result.cell_data, oldest_due.cell_data));
				end
			end
			results_seen++;
		end
	end

	initial begin
		req_t r;
		arst_n           = 1'b0;
		req_valid        = 1'b0;
		term_request     = '0;
		cfg_we           = 1'b0;
		cfg_wdata        = '0;
		blank_word       = BLANK_RESET;
		cur_col          = 0;
		cur_row          = 0;
		mismatch_count   = 0;
		results_seen     = 0;
		idle_cycles      = 0;
		burst_left       = 0;
		text_left        = 0;
		hold_off_pending = 1'b0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_steps[i]) begin
			r.operation    = directed_steps[i].op;
			r.char_word    = directed_steps[i].word;
			r.cell_address = directed_steps[i].addr;
			offer_item(r, directed_steps[i].fixed, directed_steps[i].want);
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			// The fill word only changes once every transaction has come back.
			req_valid <= 1'b0;
			while (terminal_results_due.size() != 0) @(negedge clk);
			repeat (SETTLE_CYCLES) @(negedge clk);
			cfg_we <= 1'b1;
			if (ph == 0) begin
				cfg_wdata <= 16'h0000;
				blank_word = 16'h0000;
			end else if (ph == 1) begin
				cfg_wdata <= 16'hFFFF;
				blank_word = 16'hFFFF;
			end else begin
				blank_word = WORD_W'($urandom);
				cfg_wdata <= blank_word;
			end
			@(negedge clk);
			cfg_we <= 1'b0;
			if (ph == 2) begin
				hold_off_pending = 1'b1;
			end
			repeat (PHASE_ITEMS) offer_item(next_random_item(), 1'b0, '0);
		end

		req_valid <= 1'b0;
		while (terminal_results_due.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatch_count == 0) begin
			$display("text_mode_terminal_writer_unit test passed");
		end else begin
			$display("text_mode_terminal_writer_unit test failed");
		end
		$finish;
	end

endmodule
